// File: design/mclm_pkg.sv
package mclm_pkg;

  localparam int unsigned CordicSteps = 16;
  localparam int unsigned AtanLen = 24;

  localparam logic [15:0] FullCircle = 16'd46080;
  localparam logic signed [16:0] HalfCircle = 17'sd23040;

  // 180*128/pi in Q16
  localparam logic signed [33:0] Rad2uQ16 = 34'sd480631834;
  // CORDIC gain compensation, Q30
  localparam logic signed [35:0] CordicKQ30 = 36'sd652032874;
  // floor(2^48 / 46080): binary-angle conversion by reciprocal
  localparam logic signed [33:0] BamRecip = 34'sd6108397932;

  localparam logic [15:0] TiltGainRst = 16'd4588;
  localparam logic [15:0] LagRecipRst = 16'd13107;

  // register indexes on the configuration port
  localparam logic CfgTiltGain = 1'b0;
  localparam logic CfgLagRecip = 1'b1;

  // atan(2^-i) as 32-bit binary angle
  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// File: design/magnetic_compass_lag_model_core.sv
// An out-of-service item returns the held heading in the cycle after its transfer.
// A serviceable item takes angle reduction, four CORDIC rotations and one vectoring pass of
// CordicSteps iterations (the vectoring pass is skipped when the atan2 vector is zero),
// 26 multiplies on one shared CORDIC stage and one 34x34 multiplier.
// Throughput: one item at a time; input is taken again once the result register is free.
// Reset (rst_n low, synchronous): card rate and heading to 0, registers to defaults.
module magnetic_compass_lag_model_core
  import mclm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_service,
  input  logic signed [15:0] in_roll_angle,
  input  logic signed [14:0] in_pitch_angle,
  input  logic [15:0]        in_true_heading,
  input  logic signed [14:0] in_dip_angle,
  input  logic signed [14:0] in_fore_accel,
  input  logic signed [14:0] in_side_accel,
  input  logic [15:0]        in_tick_length,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        out_indicated_heading
);

  typedef enum logic [4:0] {
    S_IDLE, S_TILT_A, S_TILT_B, S_TILT_C, S_LOAD, S_RED, S_BAM1, S_BAM2, S_BAM3,
    S_ROT, S_ROT_END, S_PMUL, S_PACC, S_VEC_INIT, S_VEC, S_TGT1, S_TGT2,
    S_ERR, S_RATIO, S_RATE1, S_RATE2, S_MOVE1, S_MOVE2
  } state_t;

  typedef enum logic [2:0] {
    ACT_T, ACT_A_SET, ACT_A_SUB, ACT_B_SET, ACT_B_SUB
  } act_t;

  state_t state_r;
  logic [15:0] gain_r, lag_r;
  logic signed [15:0] rate_r;
  logic [15:0] shown_r;
  logic out_valid_r;
  logic [15:0] out_head_r;

  logic signed [19:0] roll_r, pitch_r, ang_r;
  logic [15:0] heading_r, tick_r;
  logic signed [14:0] dip_r, fore_r, side_r;
  logic tsel_r, neg_r;
  logic [1:0] asel_r;
  logic [3:0] step_r;
  logic [31:0] q_r;
  logic signed [31:0] sphi_r, cphi_r, sth_r, cth_r, spsi_r, cpsi_r, smu_r, cmu_r;
  logic signed [35:0] x_r, y_r;
  logic signed [33:0] z_r;
  logic [4:0] iter_r;
  logic signed [32:0] t_r;
  logic signed [34:0] acc_a_r, acc_b_r;
  logic [15:0] target_r;
  logic signed [16:0] err_r;
  logic [16:0] ratio_r;
  logic signed [67:0] prod_r;

  // shared multiplier
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] mul_p;
  // product-sum step table
  logic signed [32:0] pa;
  logic signed [31:0] pb;
  act_t act;
  // shared CORDIC stage
  logic signed [35:0] xs, ys;
  logic signed [33:0] at;
  logic dir;
  logic signed [35:0] x_step, y_step;
  logic signed [33:0] z_step;

  logic signed [17:0] diff;
  logic signed [19:0] ang_ld;
  logic signed [19:0] tilt;
  logic [47:0] rem_v;
  logic [31:0] bam, bam_q, bam_f;
  logic fold;
  logic signed [32:0] mq;
  logic [16:0] tgt_v;
  logic signed [16:0] err_v;
  logic [16:0] ratio_v;
  logic signed [19:0] rate_v;
  logic signed [17:0] nh_v;

  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_indicated_heading = out_head_r;
  assign diff = 18'(err_r) - 18'(rate_r);

  always_comb begin
    pa = '0;
    pb = '0;
    act = ACT_T;
    case (step_r)
      4'd0: begin pa = 33'(cphi_r); pb = spsi_r; act = ACT_T;     end
      4'd1: begin pa = t_r;         pb = cmu_r;  act = ACT_A_SET; end
      4'd2: begin pa = 33'(sphi_r); pb = cth_r;  act = ACT_T;     end
      4'd3: begin pa = t_r;         pb = smu_r;  act = ACT_A_SUB; end
      4'd4: begin pa = 33'(sphi_r); pb = sth_r;  act = ACT_T;     end
      4'd5: begin pa = t_r;         pb = cmu_r;  act = ACT_T;     end
      4'd6: begin pa = t_r;         pb = cpsi_r; act = ACT_A_SUB; end
      4'd7: begin pa = 33'(cth_r);  pb = cpsi_r; act = ACT_T;     end
      4'd8: begin pa = t_r;         pb = cmu_r;  act = ACT_B_SET; end
      4'd9: begin pa = 33'(sth_r);  pb = smu_r;  act = ACT_B_SUB; end
      default: begin pa = '0; pb = '0; act = ACT_T; end
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_TILT_A: begin
        mul_a = {18'd0, gain_r};
        mul_b = tsel_r ? 34'(side_r) : 34'(fore_r);
      end
      S_TILT_B: begin mul_a = prod_r[33:0];            mul_b = Rad2uQ16;   end
      S_BAM1:   begin mul_a = {18'd0, ang_r[15:0]};    mul_b = BamRecip;   end
      S_BAM2:   begin mul_a = {2'd0, prod_r[47:16]};   mul_b = {18'd0, FullCircle}; end
      S_PMUL:   begin mul_a = 34'(pa);                 mul_b = 34'(pb);    end
      S_TGT1:   begin mul_a = {2'd0, z_r[31:0]};       mul_b = {18'd0, FullCircle}; end
      S_ERR:    begin mul_a = {18'd0, tick_r};         mul_b = {18'd0, lag_r}; end
      S_RATE1:  begin mul_a = 34'(diff);               mul_b = {17'd0, ratio_r}; end
      S_MOVE1:  begin mul_a = 34'(rate_r);             mul_b = {18'd0, tick_r}; end
      default:  begin mul_a = '0;                      mul_b = '0;         end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // one CORDIC iteration; rotation steers on z, vectoring on y
  always_comb begin
    xs = x_r >>> iter_r;
    ys = y_r >>> iter_r;
    at = {2'd0, atan_entry(iter_r)};
    dir = (state_r == S_ROT) ? !z_r[33] : !(y_r > 36'sd0);
    if (dir) begin
      x_step = x_r - ys;
      y_step = y_r + xs;
      z_step = z_r - at;
    end else begin
      x_step = x_r + ys;
      y_step = y_r - xs;
      z_step = z_r + at;
    end
  end

  always_comb begin
    case (asel_r)
      2'd0:    ang_ld = roll_r;
      2'd1:    ang_ld = pitch_r;
      2'd2:    ang_ld = {4'd0, heading_r};
      default: ang_ld = 20'(dip_r);
    endcase
    tilt = 20'((prod_r + 68'sh100_0000_0000) >>> 41);
    rem_v = {ang_r[15:0], 32'd0} - prod_r[47:0];
    bam = (rem_v >= 48'(FullCircle)) ? q_r + 32'd1 : q_r;
    bam_q = bam + 32'h4000_0000;
    fold = bam_q[31];
    bam_f = fold ? bam + 32'h8000_0000 : bam;
    mq = 33'((prod_r + 68'sh2000_0000) >>> 30);
    tgt_v = 17'((prod_r[48:0] + 49'h8000_0000) >> 32);
    err_v = 17'({1'b0, target_r}) - 17'({1'b0, shown_r});
    if (err_v > HalfCircle) err_v = err_v - 17'(FullCircle);
    else if (err_v < -HalfCircle) err_v = err_v + 17'(FullCircle);
    ratio_v = 17'((prod_r[32:0] + 33'h8000) >> 16);
    if (ratio_v > 17'd65536) ratio_v = 17'd65536;
    rate_v = 20'(rate_r) + 20'((prod_r + 68'sh8000) >>> 16);
    nh_v = 18'({2'd0, shown_r}) + 18'((prod_r + 68'sh8000) >>> 16);
    if (nh_v < 18'sd0) nh_v = nh_v + 18'(FullCircle);
    else if (nh_v >= 18'(FullCircle)) nh_v = nh_v - 18'(FullCircle);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      gain_r <= TiltGainRst;
      lag_r <= LagRecipRst;
      rate_r <= '0;
      shown_r <= '0;
      out_valid_r <= 1'b0;
      out_head_r <= '0;
      tsel_r <= 1'b0;
      asel_r <= '0;
      step_r <= '0;
      iter_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CfgTiltGain: gain_r <= cfg_wdata;
          CfgLagRecip: lag_r <= cfg_wdata;
          default: ;
        endcase
      end
      // a held-heading transfer reloads the result register in the same cycle
      if (out_valid_r && out_ready && !(in_valid && in_ready && !in_service))
        out_valid_r <= 1'b0;
      prod_r <= mul_p;

      case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            if (!in_service) begin
              out_valid_r <= 1'b1;
              out_head_r <= shown_r;
            end else begin
              roll_r <= 20'(in_roll_angle);
              pitch_r <= 20'(in_pitch_angle);
              heading_r <= in_true_heading;
              dip_r <= in_dip_angle;
              fore_r <= in_fore_accel;
              side_r <= in_side_accel;
              tick_r <= in_tick_length;
              tsel_r <= 1'b0;
              state_r <= S_TILT_A;
            end
          end
        end
        S_TILT_A: state_r <= S_TILT_B;
        S_TILT_B: state_r <= S_TILT_C;
        S_TILT_C: begin
          if (!tsel_r) begin
            pitch_r <= pitch_r - tilt;
            tsel_r <= 1'b1;
            state_r <= S_TILT_A;
          end else begin
            roll_r <= roll_r - tilt;
            asel_r <= 2'd0;
            state_r <= S_LOAD;
          end
        end
        S_LOAD: begin
          ang_r <= ang_ld;
          state_r <= S_RED;
        end
        S_RED: begin
          if (ang_r < 20'sd0) ang_r <= ang_r + 20'(FullCircle);
          else if (ang_r >= 20'(FullCircle)) ang_r <= ang_r - 20'(FullCircle);
          else state_r <= S_BAM1;
        end
        S_BAM1: state_r <= S_BAM2;
        S_BAM2: begin
          q_r <= prod_r[47:16];
          state_r <= S_BAM3;
        end
        S_BAM3: begin
          x_r <= CordicKQ30;
          y_r <= '0;
          z_r <= 34'(signed'(bam_f));
          neg_r <= fold;
          iter_r <= '0;
          state_r <= S_ROT;
        end
        S_ROT: begin
          x_r <= x_step;
          y_r <= y_step;
          z_r <= z_step;
          iter_r <= iter_r + 5'd1;
          if (iter_r == 5'(CordicSteps - 1)) state_r <= S_ROT_END;
        end
        S_ROT_END: begin
          case (asel_r)
            2'd0: begin
              cphi_r <= neg_r ? -x_r[31:0] : x_r[31:0];
              sphi_r <= neg_r ? -y_r[31:0] : y_r[31:0];
            end
            2'd1: begin
              cth_r <= neg_r ? -x_r[31:0] : x_r[31:0];
              sth_r <= neg_r ? -y_r[31:0] : y_r[31:0];
            end
            2'd2: begin
              cpsi_r <= neg_r ? -x_r[31:0] : x_r[31:0];
              spsi_r <= neg_r ? -y_r[31:0] : y_r[31:0];
            end
            default: begin
              cmu_r <= neg_r ? -x_r[31:0] : x_r[31:0];
              smu_r <= neg_r ? -y_r[31:0] : y_r[31:0];
            end
          endcase
          if (asel_r == 2'd3) begin
            step_r <= '0;
            state_r <= S_PMUL;
          end else begin
            asel_r <= asel_r + 2'd1;
            state_r <= S_LOAD;
          end
        end
        S_PMUL: state_r <= S_PACC;
        S_PACC: begin
          case (act)
            ACT_T:     t_r <= mq;
            ACT_A_SET: acc_a_r <= 35'(mq);
            ACT_A_SUB: acc_a_r <= acc_a_r - 35'(mq);
            ACT_B_SET: acc_b_r <= 35'(mq);
            ACT_B_SUB: acc_b_r <= acc_b_r - 35'(mq);
            default:   t_r <= mq;
          endcase
          step_r <= step_r + 4'd1;
          state_r <= (step_r == 4'd9) ? S_VEC_INIT : S_PMUL;
        end
        S_VEC_INIT: begin
          iter_r <= '0;
          if (acc_a_r == 35'sd0 && acc_b_r == 35'sd0) begin
            target_r <= '0;
            state_r <= S_ERR;
          end else begin
            if (acc_b_r < 35'sd0) begin
              x_r <= -36'(acc_b_r);
              y_r <= -36'(acc_a_r);
              z_r <= 34'h0_8000_0000;
            end else begin
              x_r <= 36'(acc_b_r);
              y_r <= 36'(acc_a_r);
              z_r <= '0;
            end
            state_r <= S_VEC;
          end
        end
        S_VEC: begin
          x_r <= x_step;
          y_r <= y_step;
          z_r <= z_step;
          iter_r <= iter_r + 5'd1;
          if (iter_r == 5'(CordicSteps - 1)) state_r <= S_TGT1;
        end
        S_TGT1: state_r <= S_TGT2;
        S_TGT2: begin
          target_r <= (tgt_v >= 17'(FullCircle)) ? 16'd0 : tgt_v[15:0];
          state_r <= S_ERR;
        end
        S_ERR: begin
          err_r <= err_v;
          state_r <= S_RATIO;
        end
        S_RATIO: begin
          ratio_r <= ratio_v;
          state_r <= S_RATE1;
        end
        S_RATE1: state_r <= S_RATE2;
        S_RATE2: begin
          if (rate_v > 20'sd32767) rate_r <= 16'sh7FFF;
          else if (rate_v < -20'sd32768) rate_r <= 16'sh8000;
          else rate_r <= rate_v[15:0];
          state_r <= S_MOVE1;
        end
        S_MOVE1: state_r <= S_MOVE2;
        S_MOVE2: begin
          shown_r <= nh_v[15:0];
          out_head_r <= nh_v[15:0];
          out_valid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_shown_range: assert property (@(posedge clk) disable iff (!rst_n)
    shown_r < FullCircle)
    else $error("card heading left the full circle");

  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_head_r < FullCircle)
    else $error("result heading out of range");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MOVE2 |=> out_valid_r && state_r == S_IDLE)
    else $error("finished item did not load the result register");

  a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROT || state_r == S_VEC) |-> iter_r < 5'(CordicSteps))
    else $error("CORDIC iteration count overran");

endmodule

// File: verif/magnetic_compass_lag_model_core_tb.sv
`timescale 1ns / 100ps

module magnetic_compass_lag_model_core_tb;
  import mclm_pkg::*;

  typedef struct {
    bit                 svc;
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic [15:0]        heading;
    logic signed [14:0] dip;
    logic signed [14:0] fore;
    logic signed [14:0] side;
    logic [15:0]        tick;
  } compass_tick_t;

  class heading_scoreboard;
    bit [15:0] tilt_gain;
    bit [15:0] lag_recip;
    longint    card_rate;
    longint    shown;
    logic [15:0] pending[$];
    bit [31:0] atan_lut[24] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81};

    function new();
      tilt_gain = TiltGainRst;
      lag_recip = LagRecipRst;
      card_rate = 0;
      shown = 0;
    endfunction

    function void set_reg(logic idx, bit [15:0] val);
      if (idx == CfgTiltGain) tilt_gain = val;
      else lag_recip = val;
    endfunction

    function longint rnd(longint v, int k);
      return (v + (64'sd1 <<< (k - 1))) >>> k;
    endfunction

    function bit [31:0] angle_to_bam(longint u);
      longint m;
      longint unsigned w;
      m = u % 46080;
      if (m < 0) m += 46080;
      w = longint'(m);
      return 32'((w << 32) / 46080);
    endfunction

    function void rotate(bit [31:0] a, output longint s, output longint c);
      bit neg;
      longint x, y, z, xs, ys;
      neg = 0;
      x = longint'(CordicKQ30);
      y = 0;
      if (32'(a + 32'h4000_0000) >= 32'h8000_0000) begin
        a = a + 32'h8000_0000;
        neg = 1;
      end
      z = longint'(signed'(a));
      for (int i = 0; i < CordicSteps && i < 24; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x -= ys; y += xs; z -= longint'(atan_lut[i]);
        end else begin
          x += ys; y -= xs; z += longint'(atan_lut[i]);
        end
      end
      c = neg ? -x : x;
      s = neg ? -y : y;
    endfunction

    function bit [31:0] vector_angle(longint y, longint x);
      bit [31:0] z;
      longint xs, ys;
      z = 0;
      if (x == 0 && y == 0) return 32'd0;
      if (x < 0) begin
        x = -x; y = -y; z = 32'h8000_0000;
      end
      for (int i = 0; i < CordicSteps && i < 24; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x += ys; y -= xs; z = z + atan_lut[i];
        end else begin
          x -= ys; y += xs; z = z - atan_lut[i];
        end
      end
      return z;
    endfunction

    function longint mq(longint p, longint q);
      return rnd(p * q, 30);
    endfunction

    function logic [15:0] predict_heading(compass_tick_t t);
      longint roll, pitch, hdg, dip, fore, side, tick;
      longint sphi, cphi, sth, cth, spsi, cpsi, smu, cmu, a, b;
      longint target, err, ratio, rate, nh;
      longint unsigned tt;
      if (!t.svc) return 16'(shown);
      roll = t.roll; pitch = t.pitch; dip = t.dip;
      fore = t.fore; side = t.side;
      hdg = longint'(t.heading);
      tick = longint'(t.tick);
      pitch -= rnd(longint'(tilt_gain) * fore * longint'(Rad2uQ16), 41);
      roll -= rnd(longint'(tilt_gain) * side * longint'(Rad2uQ16), 41);
      rotate(angle_to_bam(roll), sphi, cphi);
      rotate(angle_to_bam(pitch), sth, cth);
      rotate(angle_to_bam(hdg), spsi, cpsi);
      rotate(angle_to_bam(dip), smu, cmu);
      a = mq(mq(cphi, spsi), cmu) - mq(mq(sphi, cth), smu)
        - mq(mq(mq(sphi, sth), cmu), cpsi);
      b = mq(mq(cth, cpsi), cmu) - mq(sth, smu);
      tt = (longint'(vector_angle(a, b)) * 46080 + 64'h8000_0000) >> 32;
      if (tt >= 46080) tt = 0;
      target = longint'(tt);
      err = target - shown;
      if (err > 23040) err -= 46080;
      if (err < -23040) err += 46080;
      ratio = (tick * longint'(lag_recip) + 32768) >> 16;
      if (ratio > 65536) ratio = 65536;
      rate = card_rate + rnd((err - card_rate) * ratio, 16);
      if (rate > 32767) rate = 32767;
      if (rate < -32768) rate = -32768;
      card_rate = rate;
      nh = (shown + rnd(rate * tick, 16)) % 46080;
      if (nh < 0) nh += 46080;
      shown = nh;
      return 16'(shown);
    endfunction

    function void note_tick(compass_tick_t t);
      pending.push_back(predict_heading(t));
    endfunction

    // 0 match, 1 wrong heading, 2 nothing pending
    function int check_heading(logic [15:0] got, output logic [15:0] want);
      want = 'x;
      if (pending.size() == 0) return 2;
      want = pending.pop_front();
      return (got === want) ? 0 : 1;
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic cfg_index = CfgTiltGain;
  logic [15:0] cfg_wdata = 0;
  logic in_valid = 0;
  logic in_ready;
  logic in_service = 0;
  logic signed [15:0] in_roll_angle = 0;
  logic signed [14:0] in_pitch_angle = 0;
  logic [15:0] in_true_heading = 0;
  logic signed [14:0] in_dip_angle = 0;
  logic signed [14:0] in_fore_accel = 0;
  logic signed [14:0] in_side_accel = 0;
  logic [15:0] in_tick_length = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [15:0] out_indicated_heading;

  heading_scoreboard headings = new();
  int errors = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;

  magnetic_compass_lag_model_core dut (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  always @(posedge clk) begin
    logic [15:0] want;
    int rc;
    if (rst_n && out_valid && out_ready) begin
      rc = headings.check_heading(out_indicated_heading, want);
      if (rc == 2)
        report_mismatch($sformatf("heading %0d with none pending", out_indicated_heading));
      else if (rc == 1)
        report_mismatch($sformatf("heading got %0d want %0d", out_indicated_heading, want));
    end
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic write_reg(logic idx, logic [15:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
    headings.set_reg(idx, val);
  endtask

  task automatic send_tick(compass_tick_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_service <= t.svc;
    in_roll_angle <= t.roll;
    in_pitch_angle <= t.pitch;
    in_true_heading <= t.heading;
    in_dip_angle <= t.dip;
    in_fore_accel <= t.fore;
    in_side_accel <= t.side;
    in_tick_length <= t.tick;
    do @(posedge clk); while (!in_ready);
    headings.note_tick(t);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (headings.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic compass_tick_t make_tick(bit s, int r, int p, int h, int d,
                                              int f, int sd, int tk);
    compass_tick_t t;
    t.svc = s; t.roll = 16'(r); t.pitch = 15'(p); t.heading = 16'(h); t.dip = 15'(d);
    t.fore = 15'(f); t.side = 15'(sd); t.tick = 16'(tk);
    return t;
  endfunction

  function automatic compass_tick_t random_tick();
    compass_tick_t t;
    int k;
    t.svc = ($urandom_range(99) < 90);
    t.roll = 16'($urandom_range(46080) - 23040);
    t.pitch = 15'($urandom_range(23040) - 11520);
    t.heading = ($urandom_range(19) == 0) ? 16'($urandom_range(65535))
                                          : 16'($urandom_range(46079));
    t.dip = 15'($urandom_range(23040) - 11520);
    k = $urandom_range(3);
    t.fore = (k == 0) ? 15'($urandom_range(32767)) : 15'($urandom_range(1024) - 512);
    t.side = (k == 1) ? 15'($urandom_range(32767)) : 15'($urandom_range(1024) - 512);
    k = $urandom_range(19);
    if (k == 0) t.tick = 16'd0;
    else if (k < 5) t.tick = 16'($urandom_range(65535, 1));
    else t.tick = 16'($urandom_range(6554, 1));
    return t;
  endfunction

  initial begin
    #20ms;
    $display("magnetic_compass_lag_model_core regression: fail");
    $finish;
  end

  initial begin
    int tg[5] = '{4588, 0, 65535, 12000, 30000};
    int lr[5] = '{13107, 65535, 1, 0, 40000};
    int ip[5] = '{0, 45, 0, 34, 0};
    int sp[5] = '{0, 0, 45, 34, 0};
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: extremes, hold, wrap, big tilt, zero tick
    send_tick(make_tick(0, 23040, 11520, 46079, 11520, 16383, 16383, 65535));
    send_tick(make_tick(1, 0, 0, 0, 0, 0, 0, 65535));
    send_tick(make_tick(1, 0, 0, 46079, 0, 0, 0, 65535));
    send_tick(make_tick(1, 23040, 0, 11520, 0, 0, 0, 65535));
    send_tick(make_tick(1, -23040, 0, 34560, 0, 0, 0, 65535));
    send_tick(make_tick(1, 0, 11520, 23040, 0, 0, 0, 1));
    send_tick(make_tick(1, 0, -11520, 5000, 0, 0, 0, 30000));
    send_tick(make_tick(1, 0, 0, 23040, 11520, 0, 0, 65535));
    send_tick(make_tick(1, 0, 0, 23040, -11520, 0, 0, 65535));
    send_tick(make_tick(0, 0, 0, 0, 0, 0, 0, 0));
    send_tick(make_tick(1, 3000, 2000, 65535, 8000, 0, 0, 65535));
    send_tick(make_tick(1, 3000, 2000, 50000, 8000, 0, 0, 65535));
    send_tick(make_tick(1, 0, 0, 10000, 0, 16383, 0, 20000));
    send_tick(make_tick(1, 0, 0, 10000, 0, -16384, 0, 20000));
    send_tick(make_tick(1, 0, 0, 10000, 0, 0, 16383, 20000));
    send_tick(make_tick(1, 0, 0, 10000, 0, 0, -16384, 20000));
    send_tick(make_tick(1, 23040, 11520, 46079, 11520, -16384, -16384, 65535));
    send_tick(make_tick(1, 1000, 0, 20000, 0, 0, 0, 0));
    // nose straight up, no dip: near-zero vector into atan2
    send_tick(make_tick(1, 0, 11520, 0, 0, 0, 0, 65535));
    send_tick(make_tick(1, -32768, -16384, 0, -16384, 0, 0, 65535));
    send_tick(make_tick(1, 32767, 16383, 0, 16383, 0, 0, 65535));
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      write_reg(CfgTiltGain, 16'(tg[ph]));
      write_reg(CfgLagRecip, 16'(lr[ph]));
      send_idle_pct = ip[ph];
      stall_pct = sp[ph];
      for (int n = 0; n < 186; n++) begin
        send_tick(random_tick());
        // hold the sender until the card has caught up
        if (n == 90) drain();
      end
      drain();
    end

    stall_pct = 0;
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("magnetic_compass_lag_model_core regression: pass");
    end else begin
      $display("magnetic_compass_lag_model_core regression: fail");
    end
    $finish;
  end

endmodule

// File: magnetic_compass_lag_model_core.f
design/mclm_pkg.sv
design/magnetic_compass_lag_model_core.sv
verif/magnetic_compass_lag_model_core_tb.sv
